[rtl/core/ofrl_pkg.sv]
package ofrl_pkg;

    // Command codes carried by i_cmd.
    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_REMOVE       = 3'd1,
        CMD_POP_UNPINNED = 3'd2,
        CMD_POP_CLEAN    = 3'd3,
        CMD_CONTAINS     = 3'd4
    } t_cmd;

    // Result status codes driven on o_status.
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_DUP  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_COMMIT,
        S_REPLY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic quick;
        logic scan_start;
        logic scan_step;
        logic commit;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_end;
    } t_dp_stat;

endpackage

[rtl/core/ordered_frame_replacement_list.sv]
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------------
// command  | in        | start high, busy low | i_cmd, i_frame_id, i_pinned_mask,
//          |           |                      | i_dirty_mask
// result   | out       | o_done, one cycle    | o_status, o_out_frame, o_present,
//          |           |                      | o_list_empty
//
// One command is handled at a time. Append, contains, duplicates, unknown codes, removes
// of absent frames and pops on an empty list go from dispatch straight to the reply
// state, which raises o_done; the next transfer is accepted once the block is idle again.
// Remove and both pops walk the order store through its single read port, one entry a
// cycle, and then pass through a commit state before the reply state raises o_done.
// Reset is synchronous and active low; it empties the list. The order store itself is
// not cleared, since only entries below the count are ever read.
// The receiver cannot stall: each result is valid in the cycle o_done is high.
module ordered_frame_replacement_list #(
    parameter int FRAMES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [4:0]  i_frame_id,
    input  logic [31:0] i_pinned_mask,
    input  logic [31:0] i_dirty_mask,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [4:0]  o_out_frame,
    output logic        o_present,
    output logic        o_list_empty
);
    import ofrl_pkg::*;

    // Command and status bundles between the sequencer and the list datapath.
    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    // The sequencer accepts a transfer in idle, lets the datapath classify it, then
    // either finishes it at once or runs a scan and a commit before strobing o_done.
    ofrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .o_cmd   (ctl_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // The datapath holds the ordered store, the membership bits and the count. A scan
    // finds the first matching entry and, in the same pass, closes the gap behind it
    // by writing each later entry one slot toward the head.
    ofrl_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_ctl     (ctl_cmd),
        .o_stat        (dp_stat),
        .i_cmd         (i_cmd),
        .i_frame_id    (i_frame_id),
        .i_pinned_mask (i_pinned_mask),
        .i_dirty_mask  (i_dirty_mask),
        .o_status      (o_status),
        .o_out_frame   (o_out_frame),
        .o_present     (o_present),
        .o_list_empty  (o_list_empty)
    );

endmodule

[rtl/core/ofrl_ctrl.sv]
module ofrl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ofrl_pkg::t_dp_stat i_stat,
    output ofrl_pkg::t_ctl_cmd o_cmd,
    output logic              busy,
    output logic              o_done
);
    import ofrl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.need_scan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.quick = 1'b1;
                    n_state     = S_REPLY;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_REPLY;
            end
            S_REPLY: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The datapath only reports the end of a scan while a scan is running.
    a_scan_end_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.scan_end |-> r_state == S_SCAN)
        else $error("scan end reported outside of a scan");

    // The result strobe only ever comes straight out of a dispatch or a commit state.
    a_reply_after_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_DISPATCH || $past(r_state) == S_COMMIT))
        else $error("result strobe without a finished command");

endmodule

[rtl/core/ofrl_dp.sv]
module ofrl_dp #(
    parameter int FRAMES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ofrl_pkg::t_ctl_cmd i_cmd_ctl,
    output ofrl_pkg::t_dp_stat o_stat,
    input  logic [2:0]         i_cmd,
    input  logic [4:0]         i_frame_id,
    input  logic [31:0]        i_pinned_mask,
    input  logic [31:0]        i_dirty_mask,
    output logic [1:0]         o_status,
    output logic [4:0]         o_out_frame,
    output logic               o_present,
    output logic               o_list_empty
);
    import ofrl_pkg::*;

    localparam int AW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);

    // Order store: oldest entry at index zero.
    logic [4:0]    mem [FRAMES];

    logic [2:0]    r_cmd;
    logic [4:0]    r_frame;
    logic [31:0]   r_block;
    logic [CW-1:0] r_count;
    logic [31:0]   r_member_bits;
    logic [CW-1:0] r_rd_addr;
    logic          r_pend;
    logic [AW-1:0] r_proc_idx;
    logic [4:0]    r_rd;
    logic          r_found;
    logic [4:0]    r_hit;
    logic [1:0]    r_status;
    logic [4:0]    r_out_frame;
    logic          r_present;

    logic          is_pop;
    logic          member;
    logic          rd_en;
    logic          match;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [4:0]    wr_data;

    assign is_pop = (r_cmd == CMD_POP_UNPINNED) || (r_cmd == CMD_POP_CLEAN);
    assign member = r_member_bits[r_frame];
    assign rd_en  = i_cmd_ctl.scan_step && (r_rd_addr < r_count);
    assign match  = is_pop ? !r_block[r_rd] : (r_rd == r_frame);

    assign o_stat.need_scan = ((r_cmd == CMD_REMOVE) && member)
                            || (is_pop && (r_count != '0));
    assign o_stat.scan_end  = r_pend && (CW'(r_proc_idx) == CW'(r_count - 1'b1));

    // Single write port: appends at the tail, compaction writes one slot back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = r_frame;
        if (i_cmd_ctl.quick && (r_cmd == CMD_APPEND) && !member
                && (r_count < CW'(FRAMES))) begin
            wr_en = 1'b1;
        end else if (r_pend && r_found) begin
            wr_en   = 1'b1;
            wr_addr = r_proc_idx - 1'b1;
            wr_data = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[r_rd_addr[AW-1:0]];
        end
    end

    // Item capture, scan progress and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_cmd   <= i_cmd;
            r_frame <= i_frame_id;
            r_block <= (i_cmd == CMD_POP_UNPINNED) ? i_pinned_mask
                                                   : (i_pinned_mask | i_dirty_mask);
        end
        if (i_cmd_ctl.scan_start) begin
            r_rd_addr <= '0;
        end else if (rd_en) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        if (rd_en) begin
            r_proc_idx <= r_rd_addr[AW-1:0];
        end
        if (r_pend && !r_found && match) begin
            r_hit <= r_rd;
        end
        if (i_cmd_ctl.quick) begin
            r_out_frame <= '0;
            r_present   <= 1'b0;
            case (r_cmd)
                CMD_APPEND: begin
                    if (member) begin
                        r_status <= STAT_DUP;
                    end else if (r_count < CW'(FRAMES)) begin
                        r_status <= STAT_OK;
                    end else begin
                        r_status <= STAT_MISS;
                    end
                end
                CMD_CONTAINS: begin
                    r_status  <= STAT_OK;
                    r_present <= member;
                end
                default: begin
                    r_status <= STAT_MISS;
                end
            endcase
        end else if (i_cmd_ctl.commit) begin
            r_present   <= 1'b0;
            r_status    <= r_found ? STAT_OK : STAT_MISS;
            r_out_frame <= (r_found && is_pop) ? r_hit : 5'd0;
        end
    end

    // Control state: list length, membership, scan flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_member_bits <= '0;
            r_pend        <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            r_pend <= rd_en;
            if (i_cmd_ctl.scan_start) begin
                r_found <= 1'b0;
            end else if (r_pend && match) begin
                r_found <= 1'b1;
            end
            if (i_cmd_ctl.quick && (r_cmd == CMD_APPEND) && !member
                    && (r_count < CW'(FRAMES))) begin
                r_count                <= r_count + 1'b1;
                r_member_bits[r_frame] <= 1'b1;
            end else if (i_cmd_ctl.commit && r_found) begin
                r_count              <= r_count - 1'b1;
                r_member_bits[r_hit] <= 1'b0;
            end
        end
    end

    assign o_status     = r_status;
    assign o_out_frame  = r_out_frame;
    assign o_present    = r_present;
    assign o_list_empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FRAMES))
        else $error("entry count above capacity");

    a_member_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_member_bits) == int'(r_count))
        else $error("membership bits disagree with entry count");

    a_commit_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_ctl.commit && r_found) |=> r_count == CW'($past(r_count) - 1'b1))
        else $error("successful removal did not shorten the list");

endmodule
